/* design/rgbab_pkg.sv */
// Shared types, path codes and the rounding divide-by-255 for the RGB565 blender.
package rgbab_pkg;

  typedef logic [1:0] mode_t;

  // Which result a word takes at the output stage
  localparam mode_t MODE_SRC   = 2'd0;  // copy source, keep destination alpha
  localparam mode_t MODE_DST   = 2'd1;  // pass destination through
  localparam mode_t MODE_BLEND = 2'd2;  // full over blend

  localparam int NumCh = 3;             // red, green, blue
  localparam int DivW  = 25;            // holds the widest product plus rounding

  localparam logic [7:0] AlphaMax = 8'hff;

  // (x + ((x + 128) >> 8) + 128) >> 8
  function automatic logic [DivW-9:0] div255(input logic [DivW-1:0] x);
    logic [DivW-1:0] t;
    t = x + ((x + DivW'(128)) >> 8) + DivW'(128);
    return t[DivW-1:8];
  endfunction

endpackage

/* design/rgb565_alpha_blend.sv */
// RGB565 over-blend of a source pixel with alpha onto a destination pixel with alpha.
//
// Input channel: in_valid/in_stall carry one word of src_alpha, src_color, dst_color
// and dst_opacity. Output channel: out_valid/out_stall carry out_color and
// out_opacity, one result word for every input word, in order.
// The datapath is a four-stage pipeline: products, first divide and alpha,
// second divide, final divide with add and repack. out_valid is v4, the valid
// bit behind v1, v2 and v3. One word is taken every cycle while the
// receiver keeps up; the multiplier stages set the depth, not the rate.
// Each stage moves ahead whenever it is empty or the one after it moves, so
// bubbles close up when the receiver stalls; in_stall rises only when all four
// stages hold a word and out_stall is high. A stalled output word holds.
// Reset (rst, synchronous) empties the pipeline; there is no other state and
// nothing to configure. The fast paths (source alpha 255 or 0, destination
// alpha 0) are chosen in the first stage and ride along with the word.
module rgb565_alpha_blend
  import rgbab_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  src_alpha,
  input  logic [15:0] src_color,
  input  logic [15:0] dst_color,
  input  logic [7:0]  dst_opacity,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_color,
  output logic [7:0]  out_opacity
);

  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;

  assign adv4     = !v4 || !out_stall;
  assign adv3     = !v3 || adv4;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_stall = !adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  // ---- stage 1: path select and 8x8 products
  logic [7:0] s_ch [NumCh];
  logic [7:0] d_ch [NumCh];
  mode_t      mode_in;

  always_comb begin
    s_ch[0] = {src_color[15:11], 3'b000};
    s_ch[1] = {src_color[10:5], 2'b00};
    s_ch[2] = {src_color[4:0], 3'b000};
    d_ch[0] = {dst_color[15:11], 3'b000};
    d_ch[1] = {dst_color[10:5], 2'b00};
    d_ch[2] = {dst_color[4:0], 3'b000};
    priority if (src_alpha == AlphaMax) mode_in = MODE_SRC;
    else if (src_alpha == 8'd0)         mode_in = MODE_DST;
    else if (dst_opacity == 8'd0)       mode_in = MODE_SRC;
    else                                mode_in = MODE_BLEND;
  end

  mode_t       mode1;
  logic [15:0] src1, dst1;
  logic [7:0]  a1, da1;
  logic [15:0] sa1 [NumCh];
  logic [7:0]  dch1 [NumCh];
  logic [15:0] ada1, k1;

  always_ff @(posedge clk) begin
    if (adv1) begin
      mode1 <= mode_in;
      src1  <= src_color;
      dst1  <= dst_color;
      a1    <= src_alpha;
      da1   <= dst_opacity;
      ada1  <= 16'(src_alpha) * 16'(dst_opacity);
      k1    <= 16'(dst_opacity) * 16'(AlphaMax - src_alpha);
      for (int i = 0; i < NumCh; i++) begin
        sa1[i]  <= 16'(s_ch[i]) * 16'(src_alpha);
        dch1[i] <= d_ch[i];
      end
    end
  end

  // ---- stage 2: front term, new alpha, 8x16 back products
  logic [9:0] osum;
  logic [7:0] opa_next;

  always_comb begin
    osum = {2'b00, a1} + {2'b00, da1} - {2'b00, 8'(div255(DivW'(ada1)))};
    opa_next = (osum > 10'd255) ? AlphaMax : osum[7:0];
  end

  mode_t       mode2;
  logic [15:0] src2, dst2;
  logic [7:0]  da2, opa2;
  logic [7:0]  front2 [NumCh];
  logic [23:0] dda2 [NumCh];

  always_ff @(posedge clk) begin
    if (adv2) begin
      mode2 <= mode1;
      src2  <= src1;
      dst2  <= dst1;
      da2   <= da1;
      opa2  <= opa_next;
      for (int i = 0; i < NumCh; i++) begin
        front2[i] <= 8'(div255(DivW'(sa1[i])));
        dda2[i]   <= 24'(dch1[i]) * 24'(k1);
      end
    end
  end

  // ---- stage 3: first divide of the back term
  mode_t       mode3;
  logic [15:0] src3, dst3;
  logic [7:0]  da3, opa3;
  logic [7:0]  front3 [NumCh];
  logic [15:0] back3 [NumCh];

  always_ff @(posedge clk) begin
    if (adv3) begin
      mode3 <= mode2;
      src3  <= src2;
      dst3  <= dst2;
      da3   <= da2;
      opa3  <= opa2;
      for (int i = 0; i < NumCh; i++) begin
        front3[i] <= front2[i];
        back3[i]  <= 16'(div255(DivW'(dda2[i])));
      end
    end
  end

  // ---- stage 4: second divide, add, repack, path mux
  logic [7:0]  ch_sum [NumCh];
  logic [15:0] color_next;
  logic [7:0]  opac_next;

  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      ch_sum[i] = front3[i] + 8'(div255(DivW'(back3[i])));
    end
    unique case (mode3)
      MODE_SRC: begin
        color_next = src3;
        opac_next  = da3;
      end
      MODE_DST: begin
        color_next = dst3;
        opac_next  = da3;
      end
      MODE_BLEND: begin
        color_next = {ch_sum[0][7:3], ch_sum[1][7:2], ch_sum[2][7:3]};
        opac_next  = opa3;
      end
      default: begin
        color_next = dst3;
        opac_next  = da3;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      out_color   <= color_next;
      out_opacity <= opac_next;
    end
  end

  assign out_valid = v4;

`ifndef SYNTH
  // opaque source must pick the copy path
  a_opaque_path: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && src_alpha == AlphaMax |=> v1 && mode1 == MODE_SRC)
    else $error("opaque source word not on copy path");

  // transparent source must pick the pass-through path
  a_clear_path: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && src_alpha == 8'd0 |=> v1 && mode1 == MODE_DST)
    else $error("transparent source word not on pass-through path");

  // blending never lowers the destination alpha
  a_alpha_grows: assert property (@(posedge clk) disable iff (rst)
    v2 && mode2 == MODE_BLEND |-> opa2 >= da2)
    else $error("blended alpha below destination alpha");

  // input backs up only when every stage is full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v1 && v2 && v3 && v4 && out_stall)
    else $error("input stalled with a free pipeline stage");
`endif

endmodule

/* verif/rgb565_blend_checker.sv */
// Watches both channels of the RGB565 blender, predicts each result word and compares.
`timescale 1ns / 100ps

module rgb565_blend_checker
  import rgbab_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  src_alpha,
  input  logic [15:0] src_color,
  input  logic [15:0] dst_color,
  input  logic [7:0]  dst_opacity,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_color,
  input  logic [7:0]  out_opacity,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [15:0] color;
    logic [7:0]  opacity;
  } pixel_t;

  pixel_t expected_pixels[$];
  int     mismatches = 0;
  int     in_flight = 0;

  assign fail_count = mismatches;
  assign pending    = in_flight;

  // rounding x/255
  function automatic int unsigned div255_round(input int unsigned x);
    return (x + ((x + 128) >> 8) + 128) >> 8;
  endfunction

  function automatic int unsigned mix_channel(input int unsigned s, input int unsigned d,
                                              input int unsigned a, input int unsigned da);
    return div255_round(s * a) + div255_round(div255_round(d * da * (255 - a)));
  endfunction

  function automatic pixel_t blend_pixel(input logic [7:0] a, input logic [15:0] sc,
                                         input logic [15:0] dc, input logic [7:0] da);
    pixel_t      px;
    int unsigned ua, uda, r, g, b, op;
    ua  = a;
    uda = da;
    if (a == AlphaMax) begin
      px.color   = sc;
      px.opacity = da;
    end else if (a == 8'd0) begin
      px.color   = dc;
      px.opacity = da;
    end else if (da == 8'd0) begin
      // empty destination takes the source, alpha stays zero
      px.color   = sc;
      px.opacity = 8'd0;
    end else begin
      r  = mix_channel({sc[15:11], 3'b000}, {dc[15:11], 3'b000}, ua, uda);
      g  = mix_channel({sc[10:5], 2'b00}, {dc[10:5], 2'b00}, ua, uda);
      b  = mix_channel({sc[4:0], 3'b000}, {dc[4:0], 3'b000}, ua, uda);
      op = ua + uda - div255_round(ua * uda);
      px.color   = {r[7:3], g[7:2], b[7:3]};
      px.opacity = (op > 255) ? AlphaMax : op[7:0];
    end
    return px;
  endfunction

  always @(posedge clk) begin : watch
    pixel_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("result word %h/%h arrived with none expected", out_color, out_opacity);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_color !== want.color) begin
            $error("out_color: expected %h, got %h", want.color, out_color);
            mismatches++;
          end
          if (out_opacity !== want.opacity) begin
            $error("out_opacity: expected %h, got %h", want.opacity, out_opacity);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_pixels.push_back(blend_pixel(src_alpha, src_color, dst_color, dst_opacity));
      in_flight = expected_pixels.size();
    end
  end

endmodule

/* verif/tb_top.sv */
// Top of the RGB565 blender testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module tb_top;

  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 10;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  src_alpha;
  logic [15:0] src_color;
  logic [15:0] dst_color;
  logic [7:0]  dst_opacity;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_color;
  logic [7:0]  out_opacity;
  int          fail_count;
  int          pending;

  int   send_gap_pct = 0;
  int   stall_pct = 0;
  logic hold_request = 1'b0;
  logic hold_done = 1'b0;

  rgb565_alpha_blend DUT (.*);

  rgb565_blend_checker u_blend_check (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[rgb565_alpha_blend] ERROR");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off counted here on request
  initial begin : receiver
    int held;
    held      = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        out_stall <= 1'b1;
        held++;
        if (held == HOLD_CYCLES) begin
          held      = 0;
          hold_done = 1'b1;
        end
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Called at a rising edge; returns at the edge that took the word.
  task automatic send_word(input logic [7:0] a, input logic [15:0] sc,
                           input logic [15:0] dc, input logic [7:0] da);
    logic stalled;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    src_alpha   <= a;
    src_color   <= sc;
    dst_color   <= dc;
    dst_opacity <= da;
    // in_stall is settled by the falling edge
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic send_random();
    logic [7:0]  a, da;
    logic [15:0] sc, dc;
    int          pick;
    pick = $urandom_range(19);
    sc   = 16'($urandom);
    dc   = 16'($urandom);
    a    = 8'($urandom_range(254, 1));
    da   = 8'($urandom_range(255, 1));
    case (pick)
      0: a = 8'hff;
      1: a = 8'h00;
      2: da = 8'h00;
      3: begin
        a  = 8'($urandom);
        da = 8'($urandom);
      end
      4: a = $urandom_range(1) ? 8'd254 : 8'd1;
      5: da = 8'hff;
      default: ;
    endcase
    send_word(a, sc, dc, da);
  endtask

  task automatic run_phase(input int count, input int gap, input int stall);
    send_gap_pct = gap;
    stall_pct    = stall;
    repeat (count) send_random();
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    src_alpha   = '0;
    src_color   = '0;
    dst_color   = '0;
    dst_opacity = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // opaque source, transparent source, empty destination, then blends
    send_word(8'hff, 16'hffff, 16'h0000, 8'h00);
    send_word(8'hff, 16'h1234, 16'habcd, 8'hff);
    send_word(8'h00, 16'hffff, 16'h0000, 8'hff);
    send_word(8'h00, 16'h0000, 16'hffff, 8'h00);
    send_word(8'h01, 16'hf800, 16'h07e0, 8'h00);
    send_word(8'hfe, 16'hffff, 16'h0000, 8'h00);
    send_word(8'h80, 16'h07e0, 16'h001f, 8'h00);
    send_word(8'h01, 16'hffff, 16'hffff, 8'hff);
    send_word(8'hfe, 16'hffff, 16'hffff, 8'hff);
    send_word(8'h01, 16'h0000, 16'hffff, 8'hff);
    send_word(8'hfe, 16'h0000, 16'h0000, 8'h01);
    send_word(8'h80, 16'hf800, 16'h07e0, 8'h80);
    send_word(8'h80, 16'h001f, 16'hf800, 8'hff);
    send_word(8'hc8, 16'hffff, 16'h0000, 8'h01);
    send_word(8'h7f, 16'haaaa, 16'h5555, 8'h55);
    send_word(8'h80, 16'h5555, 16'haaaa, 8'haa);
    send_word(8'h01, 16'h0000, 16'h0000, 8'h01);
    send_word(8'h40, 16'hffff, 16'hffff, 8'hfe);
    send_word(8'hfe, 16'h07e0, 16'hf81f, 8'hfe);
    send_word(8'h01, 16'hf81f, 16'h07e0, 8'h01);

    run_phase(100, 0, 0);

    // long receiver hold-off while words keep coming, then let it all drain
    send_gap_pct = 0;
    stall_pct    = 0;
    hold_request = 1'b1;
    repeat (30) send_random();
    wait (hold_done);
    hold_request = 1'b0;
    wait_for_results();
    @(posedge clk);

    run_phase(200, 58, 0);
    run_phase(200, 0, 58);
    run_phase(200, 6, 6);
    run_phase(50, 0, 0);

    stall_pct = 0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("[rgb565_alpha_blend] OK");
    else
      $display("[rgb565_alpha_blend] ERROR");
    $finish;
  end

endmodule
